// File: rtl/ber_tlv_stream_parser_unit_macros.svh
// Assertion macros shared by the parser RTL.
`ifndef BER_TLV_STREAM_PARSER_UNIT_MACROS_SVH
`define BER_TLV_STREAM_PARSER_UNIT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define BTLV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define BTLV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: rtl/btlv_pkg.sv
package btlv_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned ByteW = 8;

  localparam logic [4:0] TagLowMask  = 5'h1f;
  localparam logic [7:0] IndefLength = 8'h80;

  typedef enum logic [2:0] {
    PH_IDENT = 3'd0,
    PH_TAGX  = 3'd1,
    PH_LEN0  = 3'd2,
    PH_LENX  = 3'd3,
    PH_VALUE = 3'd4,
    PH_DRAIN = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_VALUE  = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_INDEF     = 2'd1,
    ERR_TOO_WIDE  = 2'd2,
    ERR_TRUNCATED = 2'd3
  } err_e;

  typedef struct packed {
    kind_e             kind;
    logic [WordW-1:0]  tag_number;
    logic [2:0]        class_flags;
    logic [WordW-1:0]  value_length;
    logic [ByteW-1:0]  value_byte;
    logic              last_value;
    err_e              error_code;
  } result_t;

endpackage

// File: rtl/ber_tlv_stream_parser_unit.sv
// BER TLV stream parser.
// Input channel: one encoded byte per transaction on byte_in_i, with
// end_of_buffer_i set on the final byte of a buffer (in_valid_i / in_stall_o).
// Output channel: at most one result per input byte (out_valid_o / out_stall_i):
// kind_o 0 is a complete header (tag_number_o, class_flags_o, value_length_o),
// 1 a content byte (value_byte_o, last_value_o on the final one), 2 an error
// (error_code_o). Fields not used by a kind read as zero.
// Each byte is parsed in the cycle it is accepted; its result is registered
// in a two-entry queue that drives the outputs.
// Throughput is one byte per cycle while in_stall_o is low, as the parser
// state updates as each byte is accepted; header-only bytes produce no result.
// in_stall_o rises only when the queue holds two untaken results, so a
// stalled receiver backs up the input after two results.
// After an error, bytes up to and including the end-of-buffer byte are
// dropped. Reset empties the queue and returns the parser to expecting an
// identifier octet.
module ber_tlv_stream_parser_unit #(
  parameter int unsigned MAX_LENGTH_BYTES = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  byte_in_i,
  input  logic        end_of_buffer_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [31:0] tag_number_o,
  output logic [2:0]  class_flags_o,
  output logic [31:0] value_length_o,
  output logic [7:0]  value_byte_o,
  output logic        last_value_o,
  output logic [1:0]  error_code_o
);

  logic              take;
  logic              push;
  logic              full;
  btlv_pkg::result_t push_data;
  btlv_pkg::result_t out_data;

  assign in_stall_o = full;
  assign take       = in_valid_i && !full;

  btlv_front #(
    .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .take_i         (take),
    .byte_in_i      (byte_in_i),
    .end_of_buffer_i(end_of_buffer_i),
    .push_o         (push),
    .res_o          (push_data)
  );

  btlv_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .full_o     (full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data)
  );

  assign kind_o         = out_data.kind;
  assign tag_number_o   = out_data.tag_number;
  assign class_flags_o  = out_data.class_flags;
  assign value_length_o = out_data.value_length;
  assign value_byte_o   = out_data.value_byte;
  assign last_value_o   = out_data.last_value;
  assign error_code_o   = out_data.error_code;

endmodule

// File: rtl/btlv_front.sv
`include "ber_tlv_stream_parser_unit_macros.svh"

module btlv_front #(
  parameter int unsigned MAX_LENGTH_BYTES = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    take_i,
  input  logic [7:0]              byte_in_i,
  input  logic                    end_of_buffer_i,
  output logic                    push_o,
  output btlv_pkg::result_t       res_o
);

  localparam int unsigned LbW = $clog2(MAX_LENGTH_BYTES + 1);

  btlv_pkg::phase_e                 phase_q, phase_d;
  logic [btlv_pkg::WordW-1:0]       tag_q, tag_d;
  logic [2:0]                       flags_q, flags_d;
  logic [btlv_pkg::WordW-1:0]       len_q, len_d;
  logic [LbW-1:0]                   lbl_q, lbl_d;
  logic [btlv_pkg::WordW-1:0]       vbl_q, vbl_d;

  logic [btlv_pkg::WordW-1:0]       hdr_len;
  logic [btlv_pkg::WordW-1:0]       vbl_dec;
  logic [LbW-1:0]                   lbl_dec;
  logic                             hdr_fire;
  logic                             err_fire;
  btlv_pkg::err_e                   err_code;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= btlv_pkg::PH_IDENT;
      tag_q   <= '0;
      flags_q <= '0;
      len_q   <= '0;
      lbl_q   <= '0;
      vbl_q   <= '0;
    end else begin
      phase_q <= phase_d;
      tag_q   <= tag_d;
      flags_q <= flags_d;
      len_q   <= len_d;
      lbl_q   <= lbl_d;
      vbl_q   <= vbl_d;
    end
  end

  assign lbl_dec = (lbl_q != '0) ? lbl_q - LbW'(1) : lbl_q;
  assign vbl_dec = (vbl_q != '0) ? vbl_q - btlv_pkg::WordW'(1) : vbl_q;
  assign hdr_len = (phase_q == btlv_pkg::PH_LEN0) ?
                   {{(btlv_pkg::WordW-8){1'b0}}, byte_in_i} :
                   {len_q[btlv_pkg::WordW-9:0], byte_in_i};

  always_comb begin
    phase_d  = phase_q;
    tag_d    = tag_q;
    flags_d  = flags_q;
    len_d    = len_q;
    lbl_d    = lbl_q;
    vbl_d    = vbl_q;
    push_o   = 1'b0;
    res_o    = '0;
    hdr_fire = 1'b0;
    err_fire = 1'b0;
    err_code = btlv_pkg::ERR_TRUNCATED;

    if (take_i) begin
      case (phase_q)
        btlv_pkg::PH_IDENT: begin
          flags_d = byte_in_i[7:5];
          len_d   = '0;
          if (byte_in_i[4:0] != btlv_pkg::TagLowMask) begin
            tag_d   = {{(btlv_pkg::WordW-5){1'b0}}, byte_in_i[4:0]};
            phase_d = btlv_pkg::PH_LEN0;
          end else begin
            tag_d   = '0;
            phase_d = btlv_pkg::PH_TAGX;
          end
          err_fire = end_of_buffer_i;
        end
        btlv_pkg::PH_TAGX: begin
          tag_d = {tag_q[btlv_pkg::WordW-8:0], byte_in_i[6:0]};
          if (!byte_in_i[7]) begin
            phase_d = btlv_pkg::PH_LEN0;
          end
          err_fire = end_of_buffer_i;
        end
        btlv_pkg::PH_LEN0: begin
          if (!byte_in_i[7]) begin
            len_d    = hdr_len;
            hdr_fire = 1'b1;
          end else if (byte_in_i == btlv_pkg::IndefLength) begin
            err_fire = 1'b1;
            err_code = btlv_pkg::ERR_INDEF;
          end else if (byte_in_i[6:0] > 7'(MAX_LENGTH_BYTES)) begin
            err_fire = 1'b1;
            err_code = btlv_pkg::ERR_TOO_WIDE;
          end else begin
            lbl_d    = LbW'(byte_in_i[6:0]);
            len_d    = '0;
            phase_d  = btlv_pkg::PH_LENX;
            err_fire = end_of_buffer_i;
          end
        end
        btlv_pkg::PH_LENX: begin
          len_d = hdr_len;
          lbl_d = lbl_dec;
          if (lbl_dec == '0) begin
            hdr_fire = 1'b1;
          end else begin
            err_fire = end_of_buffer_i;
          end
        end
        btlv_pkg::PH_VALUE: begin
          vbl_d = vbl_dec;
          if (end_of_buffer_i && vbl_dec != '0) begin
            err_fire = 1'b1;
          end else begin
            push_o           = 1'b1;
            res_o.kind       = btlv_pkg::KIND_VALUE;
            res_o.value_byte = byte_in_i;
            res_o.last_value = (vbl_dec == '0);
            if (vbl_dec == '0) begin
              phase_d = btlv_pkg::PH_IDENT;
            end
          end
        end
        btlv_pkg::PH_DRAIN: begin
          if (end_of_buffer_i) begin
            phase_d = btlv_pkg::PH_IDENT;
          end
        end
        default: begin
          phase_d = btlv_pkg::PH_IDENT;
        end
      endcase

      if (hdr_fire) begin
        if (end_of_buffer_i && hdr_len != '0) begin
          err_fire = 1'b1;
          err_code = btlv_pkg::ERR_TRUNCATED;
        end else begin
          push_o             = 1'b1;
          res_o.kind         = btlv_pkg::KIND_HEADER;
          res_o.tag_number   = tag_q;
          res_o.class_flags  = flags_q;
          res_o.value_length = hdr_len;
          vbl_d              = hdr_len;
          phase_d            = (hdr_len != '0) ? btlv_pkg::PH_VALUE : btlv_pkg::PH_IDENT;
        end
      end

      if (err_fire) begin
        push_o           = 1'b1;
        res_o            = '0;
        res_o.kind       = btlv_pkg::KIND_ERROR;
        res_o.error_code = err_code;
        phase_d          = end_of_buffer_i ? btlv_pkg::PH_IDENT : btlv_pkg::PH_DRAIN;
      end
    end
  end

  `BTLV_ASSERT(a_value_count_live, (phase_q == btlv_pkg::PH_VALUE) |-> (vbl_q != '0),
               "value phase with no bytes left")
  `BTLV_ASSERT(a_lenx_count_live, (phase_q == btlv_pkg::PH_LENX) |-> (lbl_q != '0),
               "length phase with no length bytes left")
  `BTLV_ASSERT(a_push_needs_take, push_o |-> take_i, "result without an accepted byte")

endmodule

// File: rtl/btlv_queue.sv
`include "ber_tlv_stream_parser_unit_macros.svh"

module btlv_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  btlv_pkg::result_t  push_data_i,
  output logic               full_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output btlv_pkg::result_t  out_data_o
);

  btlv_pkg::result_t mem_q [2];
  logic              wr_ptr_q;
  logic              rd_ptr_q;
  logic [1:0]        cnt_q, cnt_d;
  logic              pop;

  assign pop         = out_valid_o && !out_stall_i;
  assign out_valid_o = (cnt_q != 2'd0);
  assign full_o      = (cnt_q == 2'd2);
  assign out_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    case ({push_i, pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `BTLV_ASSERT_ALWAYS(a_cnt_bound, !rst_ni || (cnt_q != 2'd3), "queue count out of range")
  `BTLV_ASSERT(a_no_push_full, push_i |-> !full_o, "push into full queue")
  `BTLV_ASSERT(a_pop_drains, (pop && !push_i) |=> (cnt_q == $past(cnt_q) - 2'd1), "pop lost")

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned MaxLenBytes = 4;
  localparam int unsigned RandomBytes = 800;
  localparam int unsigned HoldCycles  = 60;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  byte_in_i = 8'h00;
  logic        end_of_buffer_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  kind_o;
  logic [31:0] tag_number_o;
  logic [2:0]  class_flags_o;
  logic [31:0] value_length_o;
  logic [7:0]  value_byte_o;
  logic        last_value_o;
  logic [1:0]  error_code_o;

  ber_tlv_stream_parser_unit #(
    .MAX_LENGTH_BYTES(MaxLenBytes)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .byte_in_i      (byte_in_i),
    .end_of_buffer_i(end_of_buffer_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .tag_number_o   (tag_number_o),
    .class_flags_o  (class_flags_o),
    .value_length_o (value_length_o),
    .value_byte_o   (value_byte_o),
    .last_value_o   (last_value_o),
    .error_code_o   (error_code_o)
  );

  always #6 clk_i = ~clk_i;

  // Parser state mirrored by the testbench
  btlv_pkg::phase_e tlv_phase = btlv_pkg::PH_IDENT;
  logic [31:0] tag_acc = '0;
  logic [2:0]  flags_acc = '0;
  logic [31:0] len_acc = '0;
  logic [2:0]  len_bytes_left = '0;
  logic [31:0] val_bytes_left = '0;

  btlv_pkg::result_t tlv_results_due[$];
  logic [7:0]  stream_q[$];

  int unsigned n_parsed = 0;
  int unsigned n_headers = 0;
  int unsigned n_values = 0;
  int unsigned n_errors = 0;
  int unsigned n_fail = 0;
  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;
  bit          long_hold_req = 1'b0;

  function automatic void raise_tlv_error(btlv_pkg::err_e code, logic eob);
    btlv_pkg::result_t r;
    r = '0;
    r.kind = btlv_pkg::KIND_ERROR;
    r.error_code = code;
    tlv_results_due.push_back(r);
    tlv_phase = eob ? btlv_pkg::PH_IDENT : btlv_pkg::PH_DRAIN;
  endfunction

  function automatic void close_header(logic eob);
    btlv_pkg::result_t r;
    if (eob && len_acc != 0) begin
      raise_tlv_error(btlv_pkg::ERR_TRUNCATED, 1'b1);
    end else begin
      r = '0;
      r.kind = btlv_pkg::KIND_HEADER;
      r.tag_number = tag_acc;
      r.class_flags = flags_acc;
      r.value_length = len_acc;
      val_bytes_left = len_acc;
      tlv_phase = (len_acc != 0) ? btlv_pkg::PH_VALUE : btlv_pkg::PH_IDENT;
      tlv_results_due.push_back(r);
    end
  endfunction

  function automatic void decode_tlv_byte(logic [7:0] b, logic eob);
    btlv_pkg::result_t r;
    if (tlv_phase != btlv_pkg::PH_DRAIN) n_parsed++;
    case (tlv_phase)
      btlv_pkg::PH_TAGX: begin
        tag_acc = {tag_acc[24:0], b[6:0]};
        if (!b[7]) tlv_phase = btlv_pkg::PH_LEN0;
        if (eob) raise_tlv_error(btlv_pkg::ERR_TRUNCATED, 1'b1);
      end
      btlv_pkg::PH_LEN0: begin
        if (b < btlv_pkg::IndefLength) begin
          len_acc = {24'd0, b};
          close_header(eob);
        end else if (b == btlv_pkg::IndefLength) begin
          raise_tlv_error(btlv_pkg::ERR_INDEF, eob);
        end else if (32'(b[6:0]) > MaxLenBytes) begin
          raise_tlv_error(btlv_pkg::ERR_TOO_WIDE, eob);
        end else begin
          len_bytes_left = b[2:0];
          len_acc = '0;
          tlv_phase = btlv_pkg::PH_LENX;
          if (eob) raise_tlv_error(btlv_pkg::ERR_TRUNCATED, 1'b1);
        end
      end
      btlv_pkg::PH_LENX: begin
        len_acc = {len_acc[23:0], b};
        if (len_bytes_left != 0) len_bytes_left--;
        if (len_bytes_left == 0) close_header(eob);
        else if (eob) raise_tlv_error(btlv_pkg::ERR_TRUNCATED, 1'b1);
      end
      btlv_pkg::PH_VALUE: begin
        if (val_bytes_left != 0) val_bytes_left--;
        if (eob && val_bytes_left != 0) begin
          raise_tlv_error(btlv_pkg::ERR_TRUNCATED, 1'b1);
        end else begin
          r = '0;
          r.kind = btlv_pkg::KIND_VALUE;
          r.value_byte = b;
          r.last_value = (val_bytes_left == 0);
          if (val_bytes_left == 0) tlv_phase = btlv_pkg::PH_IDENT;
          tlv_results_due.push_back(r);
        end
      end
      btlv_pkg::PH_DRAIN: begin
        if (eob) tlv_phase = btlv_pkg::PH_IDENT;
      end
      default: begin
        flags_acc = b[7:5];
        tag_acc = '0;
        len_acc = '0;
        if (b[4:0] != btlv_pkg::TagLowMask) begin
          tag_acc = {27'd0, b[4:0]};
          tlv_phase = btlv_pkg::PH_LEN0;
        end else begin
          tlv_phase = btlv_pkg::PH_TAGX;
        end
        if (eob) raise_tlv_error(btlv_pkg::ERR_TRUNCATED, 1'b1);
      end
    endcase
  endfunction

  // Append one random element with the given length and number of content bytes
  function automatic void append_element(logic [31:0] vlen, int unsigned nvals);
    logic [2:0]  flags;
    int unsigned ntag;
    int unsigned nb;
    int unsigned cnt;
    flags = 3'($urandom_range(0, 7));
    if ($urandom_range(0, 4) == 0) begin
      stream_q.push_back({flags, btlv_pkg::TagLowMask});
      ntag = $urandom_range(1, 6);
      for (int unsigned i = 1; i < ntag; i++) stream_q.push_back({1'b1, 7'($urandom)});
      stream_q.push_back({1'b0, 7'($urandom)});
    end else begin
      stream_q.push_back({flags, 5'($urandom_range(0, 30))});
    end
    if (vlen < 128 && $urandom_range(0, 2) != 0) begin
      stream_q.push_back(vlen[7:0]);
    end else begin
      nb = 1;
      while (nb < 4 && (vlen >> (8 * nb)) != 0) nb++;
      cnt = $urandom_range(nb, MaxLenBytes);
      stream_q.push_back(8'h80 | 8'(cnt));
      for (int i = int'(cnt) - 1; i >= 0; i--) stream_q.push_back(vlen[8 * i +: 8]);
    end
    for (int unsigned i = 0; i < nvals; i++) stream_q.push_back(8'($urandom));
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eob);
    int unsigned gap;
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    byte_in_i <= b;
    end_of_buffer_i <= eob;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    decode_tlv_byte(b, eob);
  endtask

  // Send the staged stream, end of buffer on its final byte
  task automatic send_stream();
    for (int i = 0; i < stream_q.size(); i++) begin
      send_byte(stream_q[i], i == stream_q.size() - 1);
    end
    stream_q = {};
  endtask

  task automatic wait_results();
    in_valid_i <= 1'b0;
    while (tlv_results_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic test_well_formed();
    stream_q = {8'hfe, 8'h00};
    send_stream();
    stream_q = {8'h1f, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h7f, 8'h81, 8'h02,
                8'h00, 8'hff};
    send_stream();
    wait_results();
  endtask

  task automatic test_length_errors();
    stream_q = {8'h00, 8'h80};
    send_stream();
    stream_q = {8'h05, 8'h85, 8'haa, 8'h55};
    send_stream();
    stream_q = {8'h02, 8'hff};
    send_stream();
    wait_results();
  endtask

  task automatic test_truncation();
    stream_q = {8'h30};
    send_stream();
    stream_q = {8'h3f, 8'h81};
    send_stream();
    stream_q = {8'h02, 8'h03};
    send_stream();
    stream_q = {8'h04, 8'h84, 8'hff, 8'hff, 8'hff, 8'hff, 8'h11};
    send_stream();
    wait_results();
  endtask

  task automatic test_backpressure();
    tx_idle_en = 1'b0;
    long_hold_req = 1'b1;
    append_element(32'd40, 40);
    send_stream();
    wait_results();
    tx_idle_en = 1'b1;
  endtask

  task automatic send_random_buffer(bit clean_only);
    int unsigned mode;
    int unsigned nelem;
    int unsigned cut;
    logic [31:0] vlen;
    mode = clean_only ? 0 : $urandom_range(0, 9);
    if (mode <= 6) begin
      nelem = $urandom_range(1, 3);
      repeat (nelem) begin
        vlen = ($urandom_range(0, 19) == 0) ? 32'($urandom_range(100, 300))
                                            : 32'($urandom_range(0, 12));
        append_element(vlen, vlen);
      end
      if (mode == 6 && stream_q.size() > 1) begin
        cut = $urandom_range(1, stream_q.size() - 1);
        while (stream_q.size() > cut) void'(stream_q.pop_back());
      end
    end else if (mode == 7) begin
      append_element($urandom | 32'h0000_0100, $urandom_range(0, 3));
    end else if (mode == 8) begin
      stream_q.push_back({3'($urandom), 5'($urandom_range(0, 30))});
      stream_q.push_back(($urandom_range(0, 2) == 0) ?
                         btlv_pkg::IndefLength :
                         8'h80 | 8'($urandom_range(5, 127)));
      repeat ($urandom_range(0, 4)) stream_q.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 8)) stream_q.push_back(8'($urandom));
    end
    send_stream();
  endtask

  task automatic test_random_stream();
    int unsigned start;
    start = n_parsed;
    while (n_parsed - start < RandomBytes) send_random_buffer(1'b0);
    wait_results();
  endtask

  task automatic test_steady_stream();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (8) send_random_buffer(1'b0);
    repeat (4) send_random_buffer(1'b1);
    wait_results();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        long_hold_req = 1'b0;
        out_stall_i <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    btlv_pkg::result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (tlv_results_due.size() == 0) begin
        $error("unexpected transaction: kind %0d", kind_o);
        n_fail++;
      end else begin
        want = tlv_results_due.pop_front();
        case (want.kind)
          btlv_pkg::KIND_HEADER: n_headers++;
          btlv_pkg::KIND_VALUE:  n_values++;
          default:               n_errors++;
        endcase
        if (kind_o !== want.kind) begin
          $error("kind expected %0d actual %0d", want.kind, kind_o);
          n_fail++;
        end
        if (tag_number_o !== want.tag_number) begin
          $error("tag_number expected %0h actual %0h", want.tag_number, tag_number_o);
          n_fail++;
        end
        if (class_flags_o !== want.class_flags) begin
          $error("class_flags expected %0d actual %0d", want.class_flags, class_flags_o);
          n_fail++;
        end
        if (value_length_o !== want.value_length) begin
          $error("value_length expected %0h actual %0h", want.value_length, value_length_o);
          n_fail++;
        end
        if (value_byte_o !== want.value_byte) begin
          $error("value_byte expected %0h actual %0h", want.value_byte, value_byte_o);
          n_fail++;
        end
        if (last_value_o !== want.last_value) begin
          $error("last_value expected %0d actual %0d", want.last_value, last_value_o);
          n_fail++;
        end
        if (error_code_o !== want.error_code) begin
          $error("error_code expected %0d actual %0d", want.error_code, error_code_o);
          n_fail++;
        end
      end
    end
  end

  initial begin
    #(20_000_000);
    $display("timeout with %0d results outstanding", tlv_results_due.size());
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_well_formed();
    test_length_errors();
    test_truncation();
    test_backpressure();
    test_random_stream();
    test_steady_stream();
    repeat (20) @(posedge clk_i);
    if (tlv_results_due.size() != 0) begin
      $error("%0d expected transactions never arrived", tlv_results_due.size());
      n_fail++;
    end
    $display("Parsed %0d bytes across directed, backpressure and random buffers.", n_parsed);
    $display("Checked %0d headers, %0d content bytes and %0d error reports.",
             n_headers, n_values, n_errors);
    if (n_fail == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/btlv_pkg.sv
rtl/btlv_front.sv
rtl/btlv_queue.sv
rtl/ber_tlv_stream_parser_unit.sv
test/testbench.sv
